@@ sv/crc8frx_pkg.sv @@
`default_nettype none

package crc8frx_pkg;

  localparam int unsigned HdrLen    = 5;
  localparam int unsigned MinFrame  = 6;
  localparam int unsigned FifoDepth = 4;

  localparam logic [7:0] CrcPolyRev     = 8'hE0;
  localparam logic [7:0] SizeNibbleMask = 8'h0F;
  localparam logic [7:0] CountMax       = 8'hFF;

  localparam logic [7:0] ExpectedKeyRst = 8'd0;
  localparam logic [3:0] MaxPayloadRst  = 4'd10;
  localparam logic [7:0] ModuleCountRst = 8'd8;

  typedef enum logic [1:0] {
    REG_EXPECTED_KEY = 2'd0,
    REG_MAX_PAYLOAD  = 2'd1,
    REG_MODULE_COUNT = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_LEN_MISM  = 3'd3,
    ST_CRC_ERR   = 3'd4,
    ST_KEY_MISM  = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_word_t;

  typedef struct packed {
    logic       is_final;
    logic [7:0] data_byte;
    status_e    status;
    logic [7:0] destination;
    logic       destination_ok;
    logic [7:0] source;
    logic       source_ok;
    logic [3:0] version;
    logic [3:0] payload_size;
  } res_word_t;

  typedef struct packed {
    logic [1:0] n;
    res_word_t  w0;
    res_word_t  w1;
  } push_t;

  // reflected CRC-8, one byte: eight shift/xor steps on an 8-bit value
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPolyRev) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/crc8frx_fifo.sv @@
`default_nettype none

module crc8frx_fifo (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  crc8frx_pkg::push_t      push_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output crc8frx_pkg::res_word_t  out_data_o
);
  import crc8frx_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  res_word_t         mem_q [FifoDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  assign wr_nxt      = wr_q + PtrW'(1);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  // room for a payload word and a status word together
  assign room_o      = (cnt_q <= CntW'(FifoDepth - 2));

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.n);
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.n) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.w0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_nxt] <= push_i.w1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/crc8_frame_receive_checker.sv @@
`default_nettype none

// Frame receiver with reflected CRC-8 check. Takes one frame byte per word
// (destination, source, pad, version/size, key, payload, CRC byte; frame_end on
// the last), passes payload bytes on as they arrive when the declared size is at
// most max_payload, and closes each frame with one status word carrying the
// header fields. The header capture and the byte-wide CRC update happen in the
// cycle a word is accepted, so one byte can be taken every cycle while
// in_stall_o is low; results are registered into a four-word output queue, and
// in_stall_o rises while that queue holds more than two words (one input byte
// can yield both a payload word and a status word). The user must write
// configuration through cfg_we_i/cfg_idx_i/cfg_wdata_i only while the block is idle; the block does not enforce this.
module crc8_frame_receive_checker (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  crc8frx_pkg::rx_word_t   in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output crc8frx_pkg::res_word_t  out_data_o,
  input  wire                     cfg_we_i,
  input  wire  [1:0]              cfg_idx_i,
  input  wire  [7:0]              cfg_wdata_i
);
  import crc8frx_pkg::*;

  logic [7:0] expected_key_q, module_count_q;
  logic [3:0] max_payload_q;

  logic [7:0] byte_count_q, byte_count_d;
  logic [7:0] crc_q, crc_d;
  logic       matched_q, matched_d;
  logic [7:0] dest_q, dest_d, src_q, src_d, key_q, key_d;
  logic [3:0] ver_q, ver_d, size_q, size_d;

  logic       room, accept, emit_payload;
  logic [4:0] crc_pos;
  logic [7:0] b;
  res_word_t  pay_w, stat_w;
  push_t      push;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;
  assign b          = in_data_i.rx_byte;

  always_comb begin
    dest_d       = dest_q;
    src_d        = src_q;
    ver_d        = ver_q;
    size_d       = size_q;
    key_d        = key_q;
    crc_d        = crc_q;
    matched_d    = matched_q;
    emit_payload = 1'b0;

    unique case (byte_count_q)
      8'd0:    dest_d = b;
      8'd1:    src_d  = b;
      8'd3: begin
        ver_d  = b[7:4];
        size_d = b[3:0];
      end
      8'd4:    key_d  = b;
      default: ;
    endcase

    crc_pos = 5'(HdrLen) + {1'b0, size_d};
    priority if (byte_count_q < 8'(HdrLen)) begin
      crc_d = crc8_step(crc_q, b);
    end else if (byte_count_q < {3'b0, crc_pos}) begin
      crc_d        = crc8_step(crc_q, b);
      emit_payload = (size_d <= max_payload_q);
    end else if (byte_count_q == {3'b0, crc_pos}) begin
      matched_d = (crc_q == b);
    end else begin
    end

    // saturate past the counted range
    byte_count_d = (byte_count_q != CountMax) ? byte_count_q + 8'd1 : byte_count_q;

    pay_w           = '0;
    pay_w.data_byte = b;

    stat_w          = '0;
    stat_w.is_final = 1'b1;
    if (byte_count_d < 8'(MinFrame)) begin
      stat_w.status = ST_TOO_SHORT;
    end else begin
      stat_w.destination  = dest_d;
      stat_w.source       = src_d;
      stat_w.version      = ver_d;
      stat_w.payload_size = size_d;
      priority if (size_d > max_payload_q) begin
        stat_w.status = ST_BAD_SIZE;
      end else if (byte_count_d != {4'b0, size_d} + 8'(MinFrame)) begin
        stat_w.status = ST_LEN_MISM;
      end else if (!matched_d) begin
        stat_w.status = ST_CRC_ERR;
      end else if (key_d != expected_key_q) begin
        stat_w.status = ST_KEY_MISM;
      end else begin
        stat_w.status = ST_OK;
      end
    end
    stat_w.destination_ok = (stat_w.destination < module_count_q);
    stat_w.source_ok      = (stat_w.source < module_count_q);

    // payload word goes ahead of the status word
    push    = '0;
    push.w0 = emit_payload ? pay_w : stat_w;
    push.w1 = stat_w;
    if (accept) begin
      push.n = 2'(emit_payload) + 2'(in_data_i.frame_end);
    end

    // drop the per-frame state once the frame closes
    if (in_data_i.frame_end) begin
      byte_count_d = '0;
      crc_d        = '0;
      matched_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      crc_q        <= '0;
      matched_q    <= 1'b0;
      dest_q       <= '0;
      src_q        <= '0;
      ver_q        <= '0;
      size_q       <= '0;
      key_q        <= '0;
    end else if (accept) begin
      byte_count_q <= byte_count_d;
      crc_q        <= crc_d;
      matched_q    <= matched_d;
      dest_q       <= dest_d;
      src_q        <= src_d;
      ver_q        <= ver_d;
      size_q       <= size_d;
      key_q        <= key_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_key_q <= ExpectedKeyRst;
      max_payload_q  <= MaxPayloadRst;
      module_count_q <= ModuleCountRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_EXPECTED_KEY: expected_key_q <= cfg_wdata_i;
        REG_MAX_PAYLOAD:  max_payload_q  <= cfg_wdata_i[3:0];
        REG_MODULE_COUNT: module_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  crc8frx_fifo u_out_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import crc8frx_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0]  RegUnused  = 2'd3;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  rx_word_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  res_word_t  out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = '0;
  logic [7:0] cfg_wdata_i = '0;

  crc8_frame_receive_checker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // register copies held by the frame predictor
  logic [7:0] key_cfg   = ExpectedKeyRst;
  logic [3:0] maxpl_cfg = MaxPayloadRst;
  logic [7:0] mods_cfg  = ModuleCountRst;

  // frame state of the predictor
  logic [7:0] rx_count  = '0;
  logic [7:0] crc_acc   = '0;
  logic       crc_hit   = 1'b0;
  logic [7:0] hdr_dest  = '0;
  logic [7:0] hdr_src   = '0;
  logic [3:0] hdr_ver   = '0;
  logic [3:0] hdr_size  = '0;
  logic [7:0] hdr_key   = '0;

  res_word_t   pending_words[$];
  logic [7:0]  frame_q[$];
  int unsigned errors      = 0;
  int unsigned bytes_sent  = 0;
  int unsigned cycle_count = 0;
  logic        quiet       = 1'b0;

  // reflected CRC-8, fed one bit at a time, LSB first
  function automatic logic [7:0] crc8_fold(logic [7:0] acc, logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CrcPolyRev;
    end
    return c;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic last);
    int unsigned idx;
    int unsigned crc_pos;
    res_word_t   w;
    status_e     st;
    logic [7:0]  d, s;
    logic [3:0]  v, sz;
    idx = rx_count;
    case (idx)
      0: hdr_dest = b;
      1: hdr_src  = b;
      3: begin
        hdr_ver  = b[7:4];
        hdr_size = b[3:0];
      end
      4: hdr_key  = b;
      default: ;
    endcase
    crc_pos = HdrLen + hdr_size;
    if (idx < HdrLen) begin
      crc_acc = crc8_fold(crc_acc, b);
    end else if (idx < crc_pos) begin
      crc_acc = crc8_fold(crc_acc, b);
      if (hdr_size <= maxpl_cfg) begin
        w = '0;
        w.data_byte = b;
        pending_words.push_back(w);
      end
    end else if (idx == crc_pos) begin
      crc_hit = (crc_acc == b);
    end
    if (rx_count != CountMax) rx_count = rx_count + 8'd1;
    if (last) begin
      d = '0; s = '0; v = '0; sz = '0;
      if (rx_count < MinFrame) begin
        st = ST_TOO_SHORT;
      end else begin
        d = hdr_dest; s = hdr_src; v = hdr_ver; sz = hdr_size;
        if (hdr_size > maxpl_cfg) st = ST_BAD_SIZE;
        else if (int'(rx_count) != int'(hdr_size) + MinFrame) st = ST_LEN_MISM;
        else if (!crc_hit) st = ST_CRC_ERR;
        else if (hdr_key != key_cfg) st = ST_KEY_MISM;
        else st = ST_OK;
      end
      w = '0;
      w.is_final       = 1'b1;
      w.status         = st;
      w.destination    = d;
      w.destination_ok = d < mods_cfg;
      w.source         = s;
      w.source_ok      = s < mods_cfg;
      w.version        = v;
      w.payload_size   = sz;
      pending_words.push_back(w);
      rx_count = '0;
      crc_acc  = '0;
      crc_hit  = 1'b0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    rx_word_t w;
    w.rx_byte   = b;
    w.frame_end = last;
    if (!quiet && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic build_frame(input logic [7:0] dest, input logic [7:0] src,
                             input logic [7:0] pad, input logic [7:0] ver_size,
                             input logic [7:0] key, input int npay, input bit crc_good);
    logic [7:0] c;
    frame_q.delete();
    frame_q.push_back(dest);
    frame_q.push_back(src);
    frame_q.push_back(pad);
    frame_q.push_back(ver_size);
    frame_q.push_back(key);
    repeat (npay) frame_q.push_back(8'($urandom));
    c = '0;
    foreach (frame_q[i]) c = crc8_fold(c, frame_q[i]);
    if (!crc_good) c = c ^ 8'($urandom_range(255, 1));
    frame_q.push_back(c);
  endtask

  // addresses either anywhere or right around the module_count boundary
  function automatic logic [7:0] rand_addr();
    if ($urandom_range(1) != 0) return 8'($urandom);
    return mods_cfg + 8'($urandom_range(2, 0)) - 8'd1;
  endfunction

  // hold off the sender until every pending word is out, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] key, input logic [3:0] maxpl,
                              input logic [7:0] mods);
    logic [3:0] junk;
    junk = 4'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_EXPECTED_KEY;
    cfg_wdata_i <= key;
    @(posedge clk_i);
    cfg_idx_i   <= REG_MAX_PAYLOAD;
    cfg_wdata_i <= {junk, maxpl};
    @(posedge clk_i);
    cfg_idx_i   <= REG_MODULE_COUNT;
    cfg_wdata_i <= mods;
    @(posedge clk_i);
    // an index past the register list must be dropped
    cfg_idx_i   <= RegUnused;
    cfg_wdata_i <= 8'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    key_cfg   = key;
    maxpl_cfg = maxpl;
    mods_cfg  = mods;
  endtask

  task automatic random_frame();
    int unsigned r;
    int unsigned cut;
    logic [3:0]  sz;
    logic [7:0]  key;
    r = $urandom_range(99);
    if (r < 88) begin
      sz  = ($urandom_range(99) < 85) ? 4'($urandom_range(maxpl_cfg, 0))
                                      : 4'($urandom_range(15, 0));
      key = ($urandom_range(99) < 85) ? key_cfg : 8'($urandom);
      build_frame(rand_addr(), rand_addr(), 8'($urandom), {4'($urandom), sz}, key,
                  sz, $urandom_range(99) < 85);
      // break some frames: cut short or overrun
      if (r >= 70) begin
        if ($urandom_range(1) != 0) begin
          cut = $urandom_range(frame_q.size() - 1, 1);
          while (frame_q.size() > cut) void'(frame_q.pop_back());
        end else begin
          repeat ($urandom_range(3, 1)) frame_q.push_back(8'($urandom));
        end
      end
    end else begin
      frame_q.delete();
      repeat ($urandom_range(8, 1)) frame_q.push_back(8'($urandom));
    end
    send_frame();
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    res_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t: result word expected none, got %h", $time, out_data_o);
        errors++;
      end else begin
        want = pending_words.pop_front();
        compare_field("is_final", want.is_final, out_data_o.is_final);
        compare_field("data_byte", want.data_byte, out_data_o.data_byte);
        compare_field("status", want.status, out_data_o.status);
        compare_field("destination", want.destination, out_data_o.destination);
        compare_field("destination_ok", want.destination_ok, out_data_o.destination_ok);
        compare_field("source", want.source, out_data_o.source);
        compare_field("source_ok", want.source_ok, out_data_o.source_ok);
        compare_field("version", want.version, out_data_o.version);
        compare_field("payload_size", want.payload_size, out_data_o.payload_size);
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 18);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("crc8_frame_receive_checker regression: fail");
      $finish;
    end
  end

  // reset register values: key 0, max payload 10, eight stations
  task automatic test_clean_frames();
    build_frame(8'h00, 8'h07, 8'h00, 8'h00, 8'h00, 0, 1'b1);
    send_frame();
    build_frame(8'h08, 8'hFF, 8'hFF, 8'hFA, 8'h00, 10, 1'b1);
    send_frame();
  endtask

  task automatic test_status_order();
    frame_q = '{8'hFF};
    send_frame();
    frame_q = '{8'hA5, 8'h5A, 8'h01};
    send_frame();
    // oversize declared wins over short payload, bad CRC and wrong key
    build_frame(8'h03, 8'h04, 8'h00, 8'h2C, 8'h55, 1, 1'b0);
    send_frame();
    // length mismatch with frame end on a payload byte
    build_frame(8'h01, 8'h02, 8'h00, 8'h14, 8'h00, 4, 1'b1);
    while (frame_q.size() > 7) void'(frame_q.pop_back());
    send_frame();
    build_frame(8'h09, 8'h01, 8'h00, 8'h31, 8'h00, 1, 1'b0);
    send_frame();
    build_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h3C, 0, 1'b1);
    send_frame();
  endtask

  // run the long frame with no idling on either side
  task automatic test_long_frame();
    quiet = 1'b1;
    build_frame(8'h02, 8'h03, 8'h00, 8'h02, 8'h00, 2, 1'b1);
    repeat (250) frame_q.push_back(8'($urandom));
    send_frame();
    // counter must restart cleanly after saturation
    build_frame(8'h05, 8'h06, 8'h00, 8'h01, 8'h00, 1, 1'b1);
    send_frame();
    quiet = 1'b0;
  endtask

  task automatic test_register_extremes();
    drain();
    program_regs(8'hFF, 4'd0, 8'd0);
    build_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 0, 1'b1);
    send_frame();
    build_frame(8'h01, 8'h01, 8'h00, 8'h01, 8'hFF, 1, 1'b1);
    send_frame();
    drain();
    program_regs(8'h00, 4'd15, 8'd255);
    build_frame(8'hFE, 8'hFF, 8'h00, 8'h9F, 8'h00, 15, 1'b1);
    send_frame();
    drain();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        1: program_regs(8'($urandom), 4'd15, 8'd255);
        2: program_regs(8'($urandom), 4'd0, 8'd0);
        default: program_regs(8'($urandom), 4'($urandom), 8'($urandom_range(24, 0)));
      endcase
      quiet = (ph == 3);
      start = bytes_sent;
      while (bytes_sent - start < 12) random_frame();
    end
    drain();
    quiet = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_clean_frames();
    test_status_order();
    test_long_frame();
    test_register_extremes();
    test_random_traffic();
    drain();
    if (errors == 0) begin
      $display("crc8_frame_receive_checker regression: pass");
    end else begin
      $display("crc8_frame_receive_checker regression: fail");
    end
    $finish;
  end

endmodule
